[rtl/nsd_pkg.sv]
// ----------------------------------------------------------------------------
// nsd_pkg
// Shared types, constants and codes for the nearest-sample derivative block.
// ----------------------------------------------------------------------------
package nsd_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned DataW      = 32;
  // dividend width: 33-bit magnitude shifted by the fraction bits
  localparam int unsigned DivW       = DataW + 1 + FracBits;
  localparam int unsigned DivCntW    = $clog2(DivW + 1);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_FULL       = 3'd2,
    ST_ORDER      = 3'd3,
    ST_ZERO_SPAN  = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]        op;
    logic signed [31:0] time_value;
    logic signed [31:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] derivative;
    logic [5:0]         nearest_index;
    logic [2:0]         status;
    logic [6:0]         sample_count;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APPEND_RD,
    S_APPEND_CHK,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_WIN,
    S_RD_END,
    S_RD_START,
    S_SPAN,
    S_DIV_GO,
    S_DIV,
    S_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic clear_tab;
    logic rd_last;
    logic do_append;
    logic srch_init;
    logic srch_rd;
    logic srch_step;
    logic win_calc;
    logic rd_end;
    logic rd_start;
    logic span_calc;
    logic div_start;
    logic set_status;
    status_e status;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic order_bad;
    logic srch_done;
    logic one_sample;
    logic span_zero;
    logic div_busy;
  } stat_t;

endpackage

[rtl/nsd_ram.sv]
// ----------------------------------------------------------------------------
// nsd_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module nsd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

[rtl/nsd_div.sv]
// ----------------------------------------------------------------------------
// nsd_div
// Restoring divider, one quotient bit per cycle, with signed saturation.
// ----------------------------------------------------------------------------
module nsd_div import nsd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [32:0]  dv_i,
  input  logic [32:0]         dt_i,
  output logic                busy_o,
  output logic [31:0]         quot_o
);
  logic [DivW-1:0]    rem_q, rem_d, num_q, num_d;
  logic [DivW-1:0]    quo_q, quo_d;
  logic [32:0]        den_q, den_d;
  logic               neg_q, neg_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [DivW:0]      trial;
  logic [32:0]        mag;

  assign mag   = dv_i[32] ? 33'(-dv_i) : dv_i;
  assign trial = {rem_q, num_q[DivW-1]} - {(DivW + 1 - 33)'(0), den_q};

  // one bit per cycle
  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      num_d  = {mag, FracBits'(0)};
      den_d  = dt_i;
      neg_d  = dv_i[32];
      cnt_d  = DivCntW'(DivW);
      busy_d = 1'b1;
      quo_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[DivW-2:0], 1'b0};
      if (!trial[DivW]) begin
        rem_d = trial[DivW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DivW-2:0], num_q[DivW-1]};
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // saturate
  always_comb begin
    if (neg_q) begin
      if (quo_q >= DivW'(32'h8000_0000)) quot_o = 32'h8000_0000;
      else quot_o = 32'(-quo_q[31:0]);
    end else begin
      if (quo_q > DivW'(32'h7fff_ffff)) quot_o = 32'h7fff_ffff;
      else quot_o = quo_q[31:0];
    end
  end

  assign busy_o = busy_q;
endmodule

[rtl/nsd_datapath.sv]
// ----------------------------------------------------------------------------
// nsd_datapath
// Sample stores, fill count, search registers, window and slope arithmetic.
// ----------------------------------------------------------------------------
module nsd_datapath import nsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_t      ctrl_i,
  input  in_item_t   item_i,
  input  logic [5:0] half_window_i,
  output stat_t      stat_o,
  output out_item_t  result_o
);
  logic [CntW-1:0]   fill_q, fill_d;
  in_item_t          item_q;
  logic [IdxW-1:0]   addr;
  logic              we;
  logic [31:0]       t_rd, v_rd;
  // search bounds kept two bits wider than the index and signed so hi can go to -1
  logic signed [IdxW+1:0] lo_q, lo_d, hi_q, hi_d;
  logic [IdxW-1:0]   mid;
  logic [32:0]       best_q, best_d;
  logic              best_vld_q, best_vld_d;
  logic [IdxW-1:0]   near_q, near_d;
  logic [IdxW-1:0]   s_q, s_d, e_q, e_d;
  logic signed [31:0] te_q, ve_q;
  logic signed [32:0] dt_q, dv_q;
  logic signed [32:0] err;
  logic [32:0]       mag;
  logic [31:0]       quot;
  logic              busy;
  logic [IdxW:0]     last, sum_e;
  logic signed [31:0] deriv_q;
  logic [2:0]        status_q;
  logic              rd_end_q;

  assign mid  = IdxW'((lo_q + hi_q) >>> 1);
  assign last = (IdxW + 1)'(fill_q - 1'b1);

  // store address select; when idle the nearest sample is addressed
  always_comb begin
    priority if (ctrl_i.rd_last)   addr = IdxW'(fill_q - 1'b1);
    else if (ctrl_i.do_append)     addr = IdxW'(fill_q);
    else if (ctrl_i.srch_rd)       addr = mid;
    else if (ctrl_i.rd_end)        addr = e_q;
    else if (ctrl_i.rd_start)      addr = s_q;
    else                           addr = near_q;
  end
  assign we = ctrl_i.do_append;

  nsd_ram #(.Width(32), .Depth(TableDepth)) u_time (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(item_q.time_value), .rdata_o(t_rd));
  nsd_ram #(.Width(32), .Depth(TableDepth)) u_value (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(item_q.sample_value), .rdata_o(v_rd));

  assign err = 33'($signed(t_rd)) - 33'(item_q.time_value);
  assign mag = err[32] ? 33'(-err) : err;

  // search and window
  always_comb begin
    lo_d = lo_q; hi_d = hi_q; best_d = best_q; best_vld_d = best_vld_q;
    near_d = near_q; s_d = s_q; e_d = e_q;
    sum_e = (IdxW + 1)'(near_q) + (IdxW + 1)'(half_window_i);
    if (ctrl_i.srch_init) begin
      lo_d = '0;
      hi_d = (IdxW + 2)'(fill_q) - 1'sb1;
      best_vld_d = 1'b0;
      near_d = IdxW'(((IdxW + 2)'(fill_q) - 1'sb1) >>> 1);
    end
    if (ctrl_i.srch_step) begin
      if (!best_vld_q || mag < best_q) begin
        best_d = mag; best_vld_d = 1'b1; near_d = mid;
      end
      if (!err[32] && err != '0) hi_d = (IdxW + 2)'(mid) - 1'sb1;
      else lo_d = (IdxW + 2)'(mid) + 1'sb1;
    end
    // err here compares the nearest sample with the query time
    if (ctrl_i.win_calc) begin
      if (half_window_i != '0) begin
        s_d = ((IdxW + 1)'(near_q) > (IdxW + 1)'(half_window_i))
              ? IdxW'((IdxW + 1)'(near_q) - (IdxW + 1)'(half_window_i)) : '0;
        e_d = sum_e < last ? IdxW'(sum_e) : IdxW'(last);
      end else if (!err[32] && err != '0) begin
        s_d = near_q != '0 ? near_q - 1'b1 : '0;
        e_d = near_q;
      end else begin
        s_d = near_q;
        e_d = ((IdxW + 1)'(near_q) + 1'b1) < last ? near_q + 1'b1 : IdxW'(last);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      rd_end_q <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      rd_end_q <= ctrl_i.rd_end;
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (ctrl_i.clear_tab) fill_d = '0;
    else if (ctrl_i.do_append) fill_d = fill_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_item) item_q <= item_i;
    lo_q <= lo_d; hi_q <= hi_d; best_q <= best_d; best_vld_q <= best_vld_d;
    near_q <= near_d; s_q <= s_d; e_q <= e_d;
    // end sample latched in the cycle after its read
    if (rd_end_q) begin
      te_q <= t_rd; ve_q <= v_rd;
    end
    if (ctrl_i.span_calc) begin
      dt_q <= 33'(te_q) - 33'($signed(t_rd));
      dv_q <= 33'(ve_q) - 33'($signed(v_rd));
    end
  end

  nsd_div u_div (
    .clk_i, .rst_ni, .start_i(ctrl_i.div_start), .dv_i(dv_q), .dt_i(dt_q),
    .busy_o(busy), .quot_o(quot));

  // result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deriv_q  <= '0;
      status_q <= ST_OK;
    end else if (ctrl_i.load_item) begin
      deriv_q  <= '0;
      status_q <= ST_OK;
    end else if (ctrl_i.set_status) begin
      status_q <= ctrl_i.status;
      if (ctrl_i.status == ST_OK && !busy && item_q.op == OP_QUERY && !stat_o.one_sample)
        deriv_q <= quot;
    end
  end

  assign stat_o.empty      = fill_q == '0;
  assign stat_o.full       = fill_q == CntW'(TableDepth);
  assign stat_o.order_bad  = $signed(item_q.time_value) < $signed(t_rd);
  assign stat_o.srch_done  = lo_q > hi_q;
  assign stat_o.one_sample = !(s_q < e_q);
  assign stat_o.span_zero  = dt_q[32] || dt_q == '0;
  assign stat_o.div_busy   = busy;

  assign result_o.derivative    = deriv_q;
  assign result_o.nearest_index = (item_q.op == OP_QUERY && !stat_o.empty) ? near_q : '0;
  assign result_o.status        = status_q;
  assign result_o.sample_count  = 7'(fill_q);
endmodule

[rtl/nsd_ctrl.sv]
// ----------------------------------------------------------------------------
// nsd_ctrl
// Sequencer: append check, binary search, window reads and division.
// ----------------------------------------------------------------------------
module nsd_ctrl import nsd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  op_e      op_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  stat_t    stat_i,
  output ctrl_t    ctrl_o
);
  state_e state_q, state_d;
  logic   accept;

  assign accept = state_q == S_IDLE && in_valid_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        unique case (op_i)
          OP_APPEND: state_d = S_APPEND_RD;
          OP_QUERY:  state_d = S_SRCH_RD;
          default:   state_d = S_DONE;
        endcase
      end
      S_APPEND_RD: state_d = (stat_i.full || stat_i.empty) ? S_DONE : S_APPEND_CHK;
      S_APPEND_CHK: state_d = S_DONE;
      S_SRCH_RD: state_d = stat_i.empty ? S_DONE :
                           (stat_i.srch_done ? S_WIN : S_SRCH_CMP);
      S_SRCH_CMP: state_d = S_SRCH_RD;
      S_WIN:      state_d = S_RD_END;
      S_RD_END:   state_d = S_RD_START;
      S_RD_START: state_d = S_SPAN;
      S_SPAN:     state_d = stat_i.one_sample ? S_DONE : S_DIV_GO;
      S_DIV_GO:   state_d = stat_i.span_zero ? S_DONE : S_DIV;
      S_DIV:      state_d = stat_i.div_busy ? S_DIV : S_DONE;
      S_DONE:     if (!out_stall_i) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // outputs
  always_comb begin
    ctrl_o = '0;
    ctrl_o.status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        ctrl_o.load_item = accept;
        ctrl_o.clear_tab = accept && op_i == OP_CLEAR;
        ctrl_o.srch_init = accept && op_i == OP_QUERY;
        ctrl_o.rd_last   = accept && op_i == OP_APPEND;
      end
      S_APPEND_RD: begin
        if (stat_i.full) begin
          ctrl_o.set_status = 1'b1; ctrl_o.status = ST_FULL;
        end else if (stat_i.empty) ctrl_o.do_append = 1'b1;
        else ctrl_o.rd_last = 1'b1;
      end
      S_APPEND_CHK: begin
        if (stat_i.order_bad) begin
          ctrl_o.set_status = 1'b1; ctrl_o.status = ST_ORDER;
        end else ctrl_o.do_append = 1'b1;
      end
      S_SRCH_RD: begin
        if (stat_i.empty) begin
          ctrl_o.set_status = 1'b1; ctrl_o.status = ST_EMPTY;
        end
        ctrl_o.srch_rd = !stat_i.srch_done;
      end
      S_SRCH_CMP: ctrl_o.srch_step = 1'b1;
      S_WIN:      ctrl_o.win_calc = 1'b1;
      S_RD_END:   ctrl_o.rd_end = 1'b1;
      S_RD_START: ctrl_o.rd_start = 1'b1;
      S_SPAN:     ctrl_o.span_calc = 1'b1;
      S_DIV_GO: begin
        if (stat_i.span_zero) begin
          ctrl_o.set_status = 1'b1; ctrl_o.status = ST_ZERO_SPAN;
        end else ctrl_o.div_start = 1'b1;
      end
      S_DIV: begin
        if (!stat_i.div_busy) begin
          ctrl_o.set_status = 1'b1;
          ctrl_o.status = ST_OK;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = state_q == S_DONE;
endmodule

[rtl/nearest_sample_derivative.sv]
// ----------------------------------------------------------------------------
// nearest_sample_derivative
// Time-ordered sample table with nearest-sample slope queries.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel in_valid_i / in_stall_o carries in_item_i (op, time, value).
//  Output channel out_valid_o / out_stall_i carries out_item_o, one result
//  per request. half_window_we_i writes the window register; the user must
//  write it only while idle, as the block does not enforce this. Clear and
//  no-op go straight to the result; an append reads the last entry to check
//  order. A query on an empty table ends after its first search read. Else a
//  query runs a binary search, a read and a compare per probe (up to 7 probes
//  for 64 entries, set by the single store read port), then window, end and
//  start reads, span, divider start and a 49-bit bit-serial division.
//  One request is processed at a time; in_stall_o is high until its result
//  has been taken. While the receiver stalls, the result holds.
//  Reset clears the fill count and sets the window to 1; store contents
//  are undefined until appended.
// ----------------------------------------------------------------------------
module nearest_sample_derivative import nsd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  input  logic      half_window_we_i,
  input  logic [5:0] half_window_i
);
  ctrl_t      ctrl;
  stat_t      stat;
  logic [5:0] hw_q;

  // window register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hw_q <= 6'd1;
    else if (half_window_we_i) hw_q <= half_window_i;
  end

  nsd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .op_i(op_e'(in_item_i.op)), .in_stall_o,
    .out_valid_o, .out_stall_i, .stat_i(stat), .ctrl_o(ctrl));

  nsd_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .item_i(in_item_i), .half_window_i(hw_q),
    .stat_o(stat), .result_o(out_item_o));
endmodule

[rtl/nsd_checker.sv]
// ----------------------------------------------------------------------------
// nsd_checker
// Port-level checks on the handshakes and result fields.
// ----------------------------------------------------------------------------
module nsd_checker import nsd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);
  // a result stalled by the receiver holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");
  // no new request taken while a result waits
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken with result pending");
  // a taken request makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("not busy after taking a request");
  // count never exceeds depth
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.sample_count <= 7'(TableDepth))
    else $error("sample count beyond depth");
  // a non-ok status carries zero slope
  a_deriv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ST_OK |-> out_item_o.derivative == '0)
    else $error("slope with error status");
endmodule

bind nearest_sample_derivative nsd_checker u_nsd_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_item_o);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for nearest_sample_derivative. A predictor holds its
// own sample table and window setting, and each returned result is checked
// field by field against the oldest prediction. Directed requests cover the
// edge cases, then random append/query runs go through three idling phases.
// ----------------------------------------------------------------------------
module tb;
  import nsd_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic      half_window_we_i = 1'b0;
  logic [5:0] half_window_i = '0;

  nearest_sample_derivative dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o, .half_window_we_i, .half_window_i
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic signed [31:0] tab_time [TableDepth];
  logic signed [31:0] tab_val  [TableDepth];
  int unsigned        tab_fill = 0;
  int unsigned        win_half = 1;

  in_item_t  pending_reqs [$];
  out_item_t expected_slopes [$];
  int        err_count = 0;
  int        sender_idle_pct = 0;
  int        receiver_idle_pct = 0;
  int        quiet_cycles = 0;
  bit        accepted_any;

  function automatic logic [31:0] divide_slope(longint dv, longint dt);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] q;
    neg = dv < 0;
    mag = neg ? -dv : dv;
    q = (mag << FracBits) / dt;
    if (neg) return (q >= 64'h8000_0000) ? 32'h8000_0000 : -q[31:0];
    return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  function automatic int unsigned nearest_sample(longint t);
    int     lo;
    int     hi;
    int     mid;
    longint err;
    longint mag;
    longint best_err;
    int     best;
    lo = 0;
    hi = tab_fill - 1;
    best_err = -1;
    best = hi / 2;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      err = longint'(tab_time[mid]) - t;
      mag = err < 0 ? -err : err;
      if (best_err < 0 || mag < best_err) begin
        best_err = mag;
        best = mid;
      end
      if (err > 0) hi = mid - 1;
      else lo = mid + 1;
    end
    return best;
  endfunction

  // work out the result of one accepted request and update the table
  function automatic out_item_t predict_slope(in_item_t req);
    out_item_t   r;
    int unsigned last;
    int unsigned nr;
    int unsigned s;
    int unsigned e;
    longint      t;
    longint      dt;
    r = '0;
    t = longint'(req.time_value);
    case (op_e'(req.op))
      OP_CLEAR: tab_fill = 0;
      OP_APPEND: begin
        if (tab_fill >= TableDepth) r.status = ST_FULL;
        else if (tab_fill > 0 && t < longint'(tab_time[tab_fill-1])) r.status = ST_ORDER;
        else begin
          tab_time[tab_fill] = req.time_value;
          tab_val[tab_fill] = req.sample_value;
          tab_fill++;
        end
      end
      OP_QUERY: begin
        if (tab_fill == 0) r.status = ST_EMPTY;
        else begin
          last = tab_fill - 1;
          nr = nearest_sample(t);
          if (win_half > 0) begin
            s = nr > win_half ? nr - win_half : 0;
            e = nr + win_half < last ? nr + win_half : last;
          end else if (longint'(tab_time[nr]) > t) begin
            s = nr > 0 ? nr - 1 : 0;
            e = nr;
          end else begin
            s = nr;
            e = nr + 1 < last ? nr + 1 : last;
          end
          r.nearest_index = 6'(nr);
          if (s < e) begin
            dt = longint'(tab_time[e]) - longint'(tab_time[s]);
            if (dt <= 0) r.status = ST_ZERO_SPAN;
            else r.derivative = divide_slope(longint'(tab_val[e]) - longint'(tab_val[s]), dt);
          end
        end
      end
      default: ;
    endcase
    r.sample_count = 7'(tab_fill);
    return r;
  endfunction

  // driver: present requests from the queue, hold while stalled
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_slopes = {expected_slopes, predict_slope(in_item_i)};
        void'(pending_reqs.pop_front());
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid_i <= 1'b1;
          in_item_i  <= pending_reqs[0];
        end else in_valid_i <= 1'b0;
      end
      out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // monitor: check each result and run the watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      accepted_any = (in_valid_i && !in_stall_o);
      if (out_valid_o && !out_stall_i) begin
        accepted_any = 1'b1;
        if (expected_slopes.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_item_o);
          err_count++;
        end else begin
          if (out_item_o.derivative !== expected_slopes[0].derivative ||
              out_item_o.nearest_index !== expected_slopes[0].nearest_index ||
              out_item_o.status !== expected_slopes[0].status ||
              out_item_o.sample_count !== expected_slopes[0].sample_count) begin
            $display("%0t: mismatch expected %h actual %h", $time,
                     expected_slopes[0], out_item_o);
            err_count++;
          end
          void'(expected_slopes.pop_front());
        end
      end
      quiet_cycles = accepted_any ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= 20000) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  task automatic push_req(op_e op, logic [31:0] t, logic [31:0] v);
    in_item_t it;
    it.op = op;
    it.time_value = t;
    it.sample_value = v;
    pending_reqs = {pending_reqs, it};
  endtask

  // wait for every queued request to be taken and answered
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid_i || expected_slopes.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic set_window(logic [5:0] w);
    drain();
    half_window_i <= w;
    half_window_we_i <= 1'b1;
    @(posedge clk_i);
    half_window_we_i <= 1'b0;
    win_half = w;
  endtask

  // a run of appends with random content, some out of order or random ops, then queries
  task automatic random_run(int n);
    int          cnt;
    logic [31:0] t;
    int          step_mode;
    cnt = $urandom_range(TableDepth + 2, 1);
    if ($urandom_range(3) == 0) cnt = $urandom_range(3, 1);
    push_req(OP_CLEAR, $urandom, $urandom);
    t = $urandom_range(3) == 0 ? 32'h8000_0000 : $urandom;
    step_mode = $urandom_range(3);
    for (int i = 0; i < cnt && i < n; i++) begin
      if ($urandom_range(19) == 0) push_req(OP_APPEND, t - $urandom_range(100, 1), $urandom);
      else if ($urandom_range(29) == 0) push_req(op_e'($urandom_range(3)), $urandom, $urandom);
      else push_req(OP_APPEND, t, $urandom);
      case (step_mode)
        0: t = t + $urandom_range(3);
        1: t = t + $urandom_range(32'h10000);
        default: t = t + $urandom_range(32'h0400_0000);
      endcase
      if (t[31] == 1'b1 && step_mode != 0 && $urandom_range(1)) t = 32'h7FFF_FFFF;
    end
    for (int i = 0; i < n - cnt; i++) push_req(OP_QUERY, $urandom, $urandom);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty, nop, full, order, ties, zero span, saturation
    push_req(OP_QUERY, 0, 0);
    push_req(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(OP_APPEND, 32'h8000_0000, 32'h8000_0000);
    push_req(OP_QUERY, 0, 0);
    push_req(OP_APPEND, 32'h8000_0000, 32'h7FFF_FFFF);
    push_req(OP_QUERY, 32'h8000_0000, 0);
    push_req(OP_APPEND, 32'h8000_0001, 32'h7FFF_FFFF);
    push_req(OP_APPEND, 32'h7FFF_FFFF, 32'h8000_0000);
    push_req(OP_APPEND, 32'h0000_0000, 0);
    push_req(OP_QUERY, 32'h7FFF_FFFF, 0);
    push_req(OP_QUERY, 32'h8000_0001, 0);
    push_req(OP_CLEAR, 0, 0);
    push_req(OP_APPEND, 0, 0);
    push_req(OP_APPEND, 1, 32'h7FFF_FFFF);
    push_req(OP_APPEND, 1, 32'h8000_0000);
    push_req(OP_QUERY, 0, 0);
    push_req(OP_QUERY, 1, 0);
    set_window(0);
    push_req(OP_QUERY, 0, 0);
    push_req(OP_QUERY, 32'h7FFF_FFFF, 0);
    push_req(OP_QUERY, 32'h8000_0000, 0);
    for (int i = 3; i < TableDepth + 1; i++) push_req(OP_APPEND, i, i);
    push_req(OP_APPEND, 32'h7FFF_FFFF, 0);
    push_req(OP_QUERY, 40, 0);
    set_window(63);
    push_req(OP_QUERY, 40, 0);

    // random phases, cycling window settings including extremes
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct   = (ph == 0) ? 24 : (ph == 1) ? 76 : 0;
      receiver_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 24 : 0;
      for (int k = 0; k < 6; k++) begin
        case (k)
          0: set_window(0);
          1: set_window(63);
          2: set_window(1);
          default: set_window($urandom_range(6));
        endcase
        random_run(100);
      end
    end
    drain();
    if (err_count == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule
